// ----- rtl/knsi_pkg.sv -----
package knsi_pkg;

	// list geometry
	localparam int MAX_KEEP   = 8;
	localparam int DIST_BITS  = 32;
	localparam int INDEX_BITS = 20;

	// fixed field widths
	localparam int KEEP_W = 4;
	localparam int RANK_W = 3;

	// derived widths: count holds 0..MAX_KEEP, pointer indexes one cell
	localparam int CNT_W = $clog2(MAX_KEEP + 1);
	localparam int POS_W = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;

	localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(8);

	// controller state, one-hot
	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EMIT = 2'b10
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;   // take the offered item into the list
		logic step;   // advance the read pointer by one entry
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic at_end; // read pointer sits on the last kept entry
	} status_t;

endpackage

// ----- rtl/knsi_if.sv -----
// candidate item channel
interface knsi_in_if;
	logic                             valid;
	logic                             ready;
	logic [knsi_pkg::DIST_BITS-1:0]   distance;
	logic [knsi_pkg::INDEX_BITS-1:0]  point_index;
	logic                             first;
	logic                             last;

	modport source (output valid, distance, point_index, first, last, input ready);
	modport sink   (input valid, distance, point_index, first, last, output ready);
endinterface

// emitted list entry channel
interface knsi_out_if;
	logic                             valid;
	logic                             ready;
	logic [knsi_pkg::RANK_W-1:0]      rank;
	logic [knsi_pkg::DIST_BITS-1:0]   kept_distance;
	logic [knsi_pkg::INDEX_BITS-1:0]  kept_index;
	logic                             end_of_list;

	modport source (output valid, rank, kept_distance, kept_index, end_of_list, input ready);
	modport sink   (input valid, rank, kept_distance, kept_index, end_of_list, output ready);
endinterface

// keep_count register write channel
interface knsi_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [knsi_pkg::KEEP_W-1:0]      keep_count;

	modport source (output valid, keep_count, input ready);
	modport sink   (input valid, keep_count, output ready);
endinterface

// ----- rtl/knsi_ctrl.sv -----
module knsi_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_last,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output knsi_pkg::cmd_t     cmd,
	input  knsi_pkg::status_t  status
);

	knsi_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= knsi_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd.load  = 1'b0;
		cmd.step  = 1'b0;
		unique case (state_q)
			knsi_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
				if (in_valid && in_last) begin
					state_d = knsi_pkg::ST_EMIT;
				end
			end
			knsi_pkg::ST_EMIT: begin
				out_valid = 1'b1;
				cmd.step  = out_ready;
				if (out_ready && status.at_end) begin
					state_d = knsi_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = knsi_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/knsi_dp.sv -----
module knsi_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	// register write
	input  logic                             cfg_we,
	input  logic [knsi_pkg::KEEP_W-1:0]      cfg_keep,
	// candidate
	input  logic [knsi_pkg::DIST_BITS-1:0]   distance,
	input  logic [knsi_pkg::INDEX_BITS-1:0]  point_index,
	input  logic                             first,
	// controller link
	input  knsi_pkg::cmd_t                   cmd,
	output knsi_pkg::status_t                status,
	// entry under the read pointer
	output logic [knsi_pkg::RANK_W-1:0]      rank,
	output logic [knsi_pkg::DIST_BITS-1:0]   kept_distance,
	output logic [knsi_pkg::INDEX_BITS-1:0]  kept_index,
	output logic                             end_of_list
);

	localparam int N = knsi_pkg::MAX_KEEP;

	logic [knsi_pkg::KEEP_W-1:0]     keep_q;
	logic [knsi_pkg::CNT_W-1:0]      cnt_q;
	logic [knsi_pkg::POS_W-1:0]      rd_ptr_q;
	logic [knsi_pkg::DIST_BITS-1:0]  dist_q [N];
	logic [knsi_pkg::INDEX_BITS-1:0] idx_q  [N];

	logic [knsi_pkg::CNT_W-1:0]      k_eff;
	logic [knsi_pkg::CNT_W-1:0]      cnt_cl;
	logic [N-1:0]                    occ;
	logic [N-1:0]                    le;
	logic                            full;
	logic                            ignore;
	logic                            grow;

	// effective K: zero acts as one, clamp to list size
	always_comb begin
		if (keep_q == '0) begin
			k_eff = knsi_pkg::CNT_W'(1);
		end else if (int'(keep_q) > N) begin
			k_eff = knsi_pkg::CNT_W'(N);
		end else begin
			k_eff = knsi_pkg::CNT_W'(keep_q);
		end
	end

	// count after a new query or a lowered K
	always_comb begin
		if (first) begin
			cnt_cl = '0;
		end else if (cnt_q > k_eff) begin
			cnt_cl = k_eff;
		end else begin
			cnt_cl = cnt_q;
		end
	end

	// per-cell compare: occupied and not larger than the candidate
	always_comb begin
		for (int j = 0; j < N; j++) begin
			occ[j] = knsi_pkg::CNT_W'(j) < cnt_cl;
			le[j]  = occ[j] && (dist_q[j] <= distance);
		end
	end

	assign full   = (cnt_cl == k_eff);
	assign ignore = full && (le == occ);
	assign grow   = !ignore && !full;

	// cells: keep, take candidate, or take the neighbor above
	for (genvar g = 0; g < N; g++) begin : g_cell
		logic at_pos;
		if (g == 0) begin : g_head
			assign at_pos = !le[0];
			always_ff @(posedge clk) begin
				if (cmd.load && !ignore && at_pos) begin
					dist_q[0] <= distance;
					idx_q[0]  <= point_index;
				end
			end
		end else begin : g_body
			assign at_pos = !le[g] && le[g-1];
			always_ff @(posedge clk) begin
				if (cmd.load && !ignore && !le[g]) begin
					if (at_pos) begin
						dist_q[g] <= distance;
						idx_q[g]  <= point_index;
					end else begin
						dist_q[g] <= dist_q[g-1];
						idx_q[g]  <= idx_q[g-1];
					end
				end
			end
		end
	end

	// count, read pointer and K register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q   <= knsi_pkg::KEEP_RESET;
			cnt_q    <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (cfg_we) begin
				keep_q <= cfg_keep;
			end
			if (cmd.load) begin
				cnt_q    <= cnt_cl + knsi_pkg::CNT_W'(grow);
				rd_ptr_q <= '0;
			end else if (cmd.step) begin
				rd_ptr_q <= rd_ptr_q + knsi_pkg::POS_W'(1);
			end
		end
	end

	// readout
	assign status.at_end = (knsi_pkg::CNT_W'(rd_ptr_q) + knsi_pkg::CNT_W'(1)) == cnt_q;
	assign rank          = knsi_pkg::RANK_W'(rd_ptr_q);
	assign kept_distance = dist_q[rd_ptr_q];
	assign kept_index    = idx_q[rd_ptr_q];
	assign end_of_list   = status.at_end;

endmodule

// ----- rtl/k_nearest_sorted_insert.sv -----
// A candidate updates the list at the clock edge on which it is accepted.
// Throughput: one item per cycle while last is low; an item with last then holds off the
// input while the list streams out, one entry per output handshake, set by the single read
// pointer walking the register cells. Reset (arst_n, async) empties the list, sets K to 8
// and leaves the cell contents undefined.
module k_nearest_sorted_insert (
	input  logic        clk,
	input  logic        arst_n,
	knsi_in_if.sink     in_ch,
	knsi_out_if.source  out_ch,
	knsi_cfg_if.sink    cfg_ch
);

	knsi_pkg::cmd_t    cmd;
	knsi_pkg::status_t status;

	assign cfg_ch.ready = 1'b1;

	knsi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_last   (in_ch.last),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd),
		.status    (status)
	);

	knsi_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_ch.valid),
		.cfg_keep      (cfg_ch.keep_count),
		.distance      (in_ch.distance),
		.point_index   (in_ch.point_index),
		.first         (in_ch.first),
		.cmd           (cmd),
		.status        (status),
		.rank          (out_ch.rank),
		.kept_distance (out_ch.kept_distance),
		.kept_index    (out_ch.kept_index),
		.end_of_list   (out_ch.end_of_list)
	);

	// input and output never open together
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ch.ready && out_ch.valid))
		else $error("input accepted while list is streaming");

	// a last item starts the stream next cycle
	a_emit: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready && in_ch.last |=> out_ch.valid && out_ch.rank == '0)
		else $error("stream did not start at rank zero");

	// no stream without last
	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready && !in_ch.last |=> !out_ch.valid && in_ch.ready)
		else $error("unexpected output item");

	// ranks climb by one until the final entry
	a_rank: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.ready && !out_ch.end_of_list |=>
		out_ch.valid && out_ch.rank == knsi_pkg::RANK_W'($past(out_ch.rank) + 1'b1))
		else $error("rank sequence broken");

	// stream stops after the final entry
	a_stop: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.ready && out_ch.end_of_list |=> !out_ch.valid)
		else $error("stream ran past end of list");

endmodule
